>>> rtl/hkrb_pkg.sv
// shared constants, codes and types of the keyboard report builder
package hkrb_pkg;

  // report geometry
  localparam int KEY_SLOTS = 6;
  localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int BYTE_W    = 8;
  localparam int MODE_W    = 3;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 6;

  // modifier key codes
  localparam logic [BYTE_W-1:0] MOD_CODE_LO = 8'hE0;
  localparam logic [BYTE_W-1:0] MOD_CODE_HI = 8'hE7;

  // result item kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  // operations carried by an input transfer
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_OR_MOD  = 3'd1,
    MODE_SET_MOD = 3'd2,
    MODE_CLEAR   = 3'd3,
    MODE_SWAP    = 3'd4,
    MODE_SEND    = 3'd5
  } mode_t;

  // per-slot results of the shared compare unit
  typedef struct packed {
    logic              match;
    logic              free;
    logic              nonzero;
    logic [2:0]        hi_bit;
    logic [BYTE_W-1:0] set_byte;
  } slot_res_t;

  // write request into the current key bank
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] data;
  } key_wr_t;

  // one result item
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic              last;
    logic [CNT_W-1:0]  key_count;
    logic [BYTE_W-1:0] first_key;
    logic [BYTE_W-1:0] modifiers;
  } out_item_t;

endpackage

>>> rtl/hkrb_ifs.sv
// channel interfaces of the keyboard report builder

// operation input channel
interface hkrb_in_if;
  logic                         valid;
  logic                         ready;
  logic [hkrb_pkg::MODE_W-1:0]  mode;
  logic [hkrb_pkg::BYTE_W-1:0]  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// result channel
interface hkrb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [hkrb_pkg::IDX_W-1:0]   byte_index;
  logic [hkrb_pkg::BYTE_W-1:0]  byte_value;
  logic                         last;
  logic [hkrb_pkg::CNT_W-1:0]   key_count;
  logic [hkrb_pkg::BYTE_W-1:0]  first_key;
  logic [hkrb_pkg::BYTE_W-1:0]  modifiers;

  modport source (output valid, output kind, output byte_index, output byte_value,
                  output last, output key_count, output first_key, output modifiers,
                  input ready);
  modport sink   (input valid, input kind, input byte_index, input byte_value,
                  input last, input key_count, input first_key, input modifiers,
                  output ready);
endinterface

// configuration write channel
interface hkrb_cfg_if;
  logic valid;
  logic ready;
  logic nkro_enable;

  modport source (output valid, output nkro_enable, input ready);
  modport sink   (input valid, input nkro_enable, output ready);
endinterface

>>> rtl/hkrb_slot_alu.sv
// shared per-slot compare unit used by the add and status slot walks
module hkrb_slot_alu (
  input  logic [hkrb_pkg::BYTE_W-1:0] code,
  input  logic [hkrb_pkg::BYTE_W-1:0] cur_byte,
  input  logic [hkrb_pkg::BYTE_W-1:0] prev_byte,
  output hkrb_pkg::slot_res_t         res
);
  import hkrb_pkg::*;

  // compares, highest set bit and bitmap set
  always_comb begin
    res          = '0;
    res.match    = (prev_byte == code);
    res.free     = (prev_byte == '0) && (cur_byte == '0);
    res.nonzero  = (cur_byte != '0);
    for (int b = 0; b < BYTE_W; b++) begin
      if (cur_byte[b]) res.hi_bit = 3'(b);
    end
    res.set_byte = cur_byte | (8'd1 << code[2:0]);
  end

endmodule

>>> rtl/hkrb_key_store.sv
// two banks of key bytes with one slot read and one write into the current bank
module hkrb_key_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         active,
  input  logic [hkrb_pkg::SLOT_W-1:0]  rd_slot,
  input  hkrb_pkg::key_wr_t            wr,
  output logic [hkrb_pkg::BYTE_W-1:0]  cur_byte,
  output logic [hkrb_pkg::BYTE_W-1:0]  prev_byte
);
  import hkrb_pkg::*;

  logic [BYTE_W-1:0] bank0_r [KEY_SLOTS];
  logic [BYTE_W-1:0] bank1_r [KEY_SLOTS];
  logic [BYTE_W-1:0] rd0;
  logic [BYTE_W-1:0] rd1;

  // slot read of both banks, current and previous by bank select
  assign rd0       = bank0_r[rd_slot];
  assign rd1       = bank1_r[rd_slot];
  assign cur_byte  = active ? rd1 : rd0;
  assign prev_byte = active ? rd0 : rd1;

  // bank storage, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        bank0_r[i] <= '0;
        bank1_r[i] <= '0;
      end
    end else if (wr.en) begin
      if (active) bank1_r[wr.slot] <= wr.data;
      else        bank0_r[wr.slot] <= wr.data;
    end
  end

endmodule

>>> rtl/hid_keyboard_report_builder_top.sv
// top level: sequencer of the keyboard report builder
// Each operation is worked one at a time by a small sequencer that walks the key slots through
// one shared compare unit, one slot per cycle. Add-code and clear may first walk the slots for
// the operation, add-code may then make a placement write, and every operation ends in the
// status walk; send then emits the modifier byte and one byte per key slot. A single output
// register holds a finished result, so the next operation is taken while that result waits;
// a stalled output channel stretches only the emitting cycles. Configuration writes are taken
// in any cycle and must only be made with the block idle.
module hid_keyboard_report_builder_top (
  input  logic       clk,
  input  logic       rst_n,
  hkrb_in_if.sink    in_ch,
  hkrb_out_if.source out_ch,
  hkrb_cfg_if.sink   cfg_ch
);
  import hkrb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_PLACE, S_STAT, S_STAT_OUT, S_SEND_MOD, S_SEND_KEY
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [BYTE_W-1:0] value_r, value_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;
  logic              active_r, active_nxt;
  logic              nkro_r, nkro_nxt;
  logic [BYTE_W-1:0] mods_r [2];
  logic [BYTE_W-1:0] mods_nxt [2];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] fk_r, fk_nxt;
  logic              fk_found_r, fk_found_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              to_stat;
  logic              last_slot;
  logic              out_free;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] prev_byte;
  key_wr_t           wr;
  slot_res_t         sr;

  // key banks and shared slot unit
  hkrb_key_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .active    (active_r),
    .rd_slot   (slot_r),
    .wr        (wr),
    .cur_byte  (cur_byte),
    .prev_byte (prev_byte)
  );

  hkrb_slot_alu u_alu (
    .code      (value_r),
    .cur_byte  (cur_byte),
    .prev_byte (prev_byte),
    .res       (sr)
  );

  // handshake outputs
  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.byte_index = out_r.byte_index;
  assign out_ch.byte_value = out_r.byte_value;
  assign out_ch.last       = out_r.last;
  assign out_ch.key_count  = out_r.key_count;
  assign out_ch.first_key  = out_r.first_key;
  assign out_ch.modifiers  = out_r.modifiers;

  assign last_slot = (slot_r == SLOT_W'(KEY_SLOTS - 1));
  assign out_free  = !out_valid_r || out_ch.ready;

  // sequencer next-state logic
  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    mode_nxt       = mode_r;
    value_nxt      = value_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    active_nxt     = active_r;
    nkro_nxt       = nkro_r;
    mods_nxt       = mods_r;
    count_nxt      = count_r;
    fk_nxt         = fk_r;
    fk_found_nxt   = fk_found_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    wr             = '0;
    to_stat        = 1'b0;

    // configuration transfer
    if (cfg_ch.valid) nkro_nxt = cfg_ch.nkro_enable;

    // output register drains on a transfer
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt       = in_ch.mode;
          value_nxt      = in_ch.value;
          slot_nxt       = '0;
          free_found_nxt = 1'b0;
          state_nxt      = S_OP;
        end
      end

      S_OP: begin
        case (mode_t'(mode_r))
          MODE_ADD: begin
            if (value_r inside {[MOD_CODE_LO:MOD_CODE_HI]}) begin
              mods_nxt[active_r] = mods_r[active_r] | (8'd1 << value_r[2:0]);
              to_stat = 1'b1;
            end else if (nkro_r) begin
              // bitmap: set the bit when the walk reaches its byte
              if (8'(slot_r) == (value_r >> 3)) wr = '{1'b1, slot_r, sr.set_byte};
              if (last_slot) to_stat = 1'b1;
              else           slot_nxt = slot_r + SLOT_W'(1);
            end else begin
              // slot list: keep the previous slot, else remember the first free one
              if (sr.match) begin
                wr = '{1'b1, slot_r, value_r};
                to_stat = 1'b1;
              end else begin
                if (sr.free && !free_found_r) begin
                  free_found_nxt = 1'b1;
                  free_slot_nxt  = slot_r;
                end
                if (last_slot) begin
                  if (free_found_r || sr.free) state_nxt = S_PLACE;
                  else                         to_stat   = 1'b1;
                end else begin
                  slot_nxt = slot_r + SLOT_W'(1);
                end
              end
            end
          end
          MODE_OR_MOD: begin
            mods_nxt[active_r] = mods_r[active_r] | value_r;
            to_stat = 1'b1;
          end
          MODE_SET_MOD: begin
            mods_nxt[active_r] = value_r;
            to_stat = 1'b1;
          end
          MODE_CLEAR: begin
            mods_nxt[active_r] = '0;
            wr = '{1'b1, slot_r, 8'd0};
            if (last_slot) to_stat = 1'b1;
            else           slot_nxt = slot_r + SLOT_W'(1);
          end
          MODE_SWAP: begin
            active_nxt = ~active_r;
            to_stat = 1'b1;
          end
          default: begin
            to_stat = 1'b1;
          end
        endcase
      end

      S_PLACE: begin
        wr = '{1'b1, free_slot_r, value_r};
        to_stat = 1'b1;
      end

      // status walk over the current bank
      S_STAT: begin
        if (sr.nonzero) count_nxt = count_r + CNT_W'(1);
        if (nkro_r) begin
          if (sr.nonzero && !fk_found_r) begin
            fk_found_nxt = 1'b1;
            fk_nxt       = (8'(slot_r) << 3) | 8'(sr.hi_bit);
          end
        end else if (slot_r == '0) begin
          fk_nxt = cur_byte;
        end
        if (last_slot) begin
          slot_nxt  = '0;
          state_nxt = (mode_t'(mode_r) == MODE_SEND) ? S_SEND_MOD : S_STAT_OUT;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end

      S_STAT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{KIND_STATUS, '0, '0, 1'b1, count_r, fk_r, mods_r[active_r]};
          state_nxt = S_IDLE;
        end
      end

      S_SEND_MOD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{KIND_BYTE, '0, mods_r[active_r], 1'b0, count_r, fk_r,
                      mods_r[active_r]};
          slot_nxt  = '0;
          state_nxt = S_SEND_KEY;
        end
      end

      S_SEND_KEY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{KIND_BYTE, IDX_W'(slot_r) + IDX_W'(1), cur_byte, last_slot,
                      count_r, fk_r, mods_r[active_r]};
          if (last_slot) state_nxt = S_IDLE;
          else           slot_nxt  = slot_r + SLOT_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // start of the status walk
    if (to_stat) begin
      slot_nxt     = '0;
      count_nxt    = '0;
      fk_nxt       = '0;
      fk_found_nxt = 1'b0;
      state_nxt    = S_STAT;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_r       <= '0;
      free_found_r <= 1'b0;
      active_r     <= 1'b0;
      nkro_r       <= 1'b0;
      mods_r[0]    <= '0;
      mods_r[1]    <= '0;
      count_r      <= '0;
      fk_r         <= '0;
      fk_found_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      free_found_r <= free_found_nxt;
      active_r     <= active_nxt;
      nkro_r       <= nkro_nxt;
      mods_r       <= mods_nxt;
      count_r      <= count_nxt;
      fk_r         <= fk_nxt;
      fk_found_r   <= fk_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    mode_r      <= mode_nxt;
    value_r     <= value_nxt;
    free_slot_r <= free_slot_nxt;
    out_r       <= out_nxt;
  end

  // an accepted operation keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after an accepted operation");

  // a status item always ends its operation
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_STATUS) |-> out_r.last)
    else $error("status item without last");

  // the final report byte sits at the last key slot
  a_send_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_BYTE && out_r.last) |->
      (out_r.byte_index == IDX_W'(KEY_SLOTS)))
    else $error("last report byte at wrong index");

  // key count never exceeds the slot count
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.key_count <= CNT_W'(KEY_SLOTS)))
    else $error("key count beyond slot count");

endmodule

>>> tb/tb_hid_keyboard_report_builder_top.sv
// self-checking testbench of the keyboard report builder: slot and bitmap reports, stalls
module tb_hid_keyboard_report_builder_top;
  import hkrb_pkg::*;

  // operation codes the block leaves unused
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  // longest operation of the block, an add or a send
  localparam int OP_CYCLES_MAX = 2 * KEY_SLOTS + 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hkrb_in_if  in_if ();
  hkrb_out_if out_if ();
  hkrb_cfg_if cfg_if ();

  hid_keyboard_report_builder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // mirror of the report banks
  logic [BYTE_W-1:0] key_bank [2][KEY_SLOTS];
  logic [BYTE_W-1:0] mod_bank [2];
  logic              live_bank;
  logic              nkro_on;

  out_item_t report_items_q [$];
  int error_count = 0;

  // traffic shaping
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_ADD;
    in_if.value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.nkro_enable = 1'b0;
    out_if.ready = 1'b0;
    for (int b = 0; b < 2; b++) begin
      mod_bank[b] = '0;
      for (int i = 0; i < KEY_SLOTS; i++) key_bank[b][i] = '0;
    end
    live_bank = 1'b0;
    nkro_on = 1'b0;
  end

  // work out the result items of one accepted operation
  task automatic build_report_items(input logic [MODE_W-1:0] op, input logic [BYTE_W-1:0] val);
    logic              prev;
    logic              placed;
    int                free_slot;
    int                bit_pos;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] first;
    logic              found;
    out_item_t         item;
    prev = ~live_bank;
    case (op)
      MODE_ADD: begin
        if (val >= MOD_CODE_LO && val <= MOD_CODE_HI) begin
          mod_bank[live_bank][val[2:0]] = 1'b1;
        end else if (nkro_on) begin
          // codes past the bitmap are dropped
          if (val[7:3] < KEY_SLOTS) key_bank[live_bank][val[7:3]][val[2:0]] = 1'b1;
        end else begin
          // keep the slot of the previous report, else first slot empty in both banks
          placed = 1'b0;
          free_slot = -1;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (!placed) begin
              if (key_bank[prev][i] == val) begin
                key_bank[live_bank][i] = val;
                placed = 1'b1;
              end else if (free_slot < 0 && key_bank[prev][i] == '0 &&
                           key_bank[live_bank][i] == '0) begin
                free_slot = i;
              end
            end
          end
          if (!placed && free_slot >= 0) key_bank[live_bank][free_slot] = val;
        end
      end
      MODE_OR_MOD:  mod_bank[live_bank] = mod_bank[live_bank] | val;
      MODE_SET_MOD: mod_bank[live_bank] = val;
      MODE_CLEAR: begin
        mod_bank[live_bank] = '0;
        for (int i = 0; i < KEY_SLOTS; i++) key_bank[live_bank][i] = '0;
      end
      MODE_SWAP: live_bank = ~live_bank;
      default: ;
    endcase

    // status of the current bank
    count = '0;
    for (int i = 0; i < KEY_SLOTS; i++)
      if (key_bank[live_bank][i] != '0) count = count + CNT_W'(1);
    if (!nkro_on) begin
      first = key_bank[live_bank][0];
    end else begin
      // lowest nonzero byte, highest bit in it; empty bitmap reads zero
      first = '0;
      found = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (!found && key_bank[live_bank][i] != '0) begin
          found = 1'b1;
          bit_pos = 0;
          for (int b = 0; b < 8; b++)
            if (key_bank[live_bank][i][b]) bit_pos = b;
          first = BYTE_W'(i * 8 + bit_pos);
        end
      end
    end

    item.key_count = count;
    item.first_key = first;
    item.modifiers = mod_bank[live_bank];
    if (op == MODE_SEND) begin
      for (int i = 0; i <= KEY_SLOTS; i++) begin
        item.kind = KIND_BYTE;
        item.byte_index = IDX_W'(i);
        item.byte_value = (i == 0) ? mod_bank[live_bank] : key_bank[live_bank][i-1];
        item.last = (i == KEY_SLOTS);
        report_items_q.push_back(item);
      end
    end else begin
      item.kind = KIND_STATUS;
      item.byte_index = '0;
      item.byte_value = '0;
      item.last = 1'b1;
      report_items_q.push_back(item);
    end
  endtask

  // predict on every accepted operation, track configuration writes
  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) nkro_on = cfg_if.nkro_enable;
    if (rst_n && in_if.valid && in_if.ready) build_report_items(in_if.mode, in_if.value);
  end

  // result receiver: random stalls plus a counted hold-off
  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (report_items_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d index %0d value %0d",
                 $time, out_if.kind, out_if.byte_index, out_if.byte_value);
        error_count++;
      end else begin
        want = report_items_q.pop_front();
        check_field("kind", want.kind, out_if.kind);
        check_field("byte_index", want.byte_index, out_if.byte_index);
        check_field("byte_value", want.byte_value, out_if.byte_value);
        check_field("last", want.last, out_if.last);
        check_field("key_count", want.key_count, out_if.key_count);
        check_field("first_key", want.first_key, out_if.first_key);
        check_field("modifiers", want.modifiers, out_if.modifiers);
      end
    end
  end

  // offer one operation, with a random gap first, and hold it until the transfer
  task automatic send_op(input logic [MODE_W-1:0] op, input logic [BYTE_W-1:0] val);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= op;
    in_if.value <= val;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // stop offering and wait for every predicted result
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    // let the prediction of the last transfer land first
    @(posedge clk);
    while (report_items_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_nkro(input logic on);
    cfg_if.valid <= 1'b1;
    cfg_if.nkro_enable <= on;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // random operation, weighted towards adds from a small code pool
  task automatic pick_random_op(output logic [MODE_W-1:0] op, output logic [BYTE_W-1:0] val);
    int r;
    r = $urandom_range(99);
    val = BYTE_W'($urandom_range(255));
    if (r < 55) begin
      op = MODE_ADD;
      r = $urandom_range(99);
      if (r < 55) val = nkro_on ? BYTE_W'($urandom_range(8 * KEY_SLOTS - 1))
                                : BYTE_W'($urandom_range(4, 11));
      else if (r < 70) val = MOD_CODE_LO | BYTE_W'($urandom_range(7));
    end else if (r < 67) begin
      op = MODE_SWAP;
    end else if (r < 78) begin
      op = MODE_SEND;
    end else if (r < 84) begin
      op = MODE_CLEAR;
    end else if (r < 90) begin
      op = MODE_OR_MOD;
    end else if (r < 96) begin
      op = MODE_SET_MOD;
    end else begin
      op = r[0] ? MODE_SPARE_7 : MODE_SPARE_6;
    end
  endtask

  // slot report: reuse, repeats, zero code, full list, spare modes, modifiers
  task automatic test_slot_report();
    write_nkro(1'b0);
    send_op(MODE_ADD, 8'h04);
    send_op(MODE_ADD, 8'h04);
    send_op(MODE_ADD, MOD_CODE_LO);
    send_op(MODE_ADD, MOD_CODE_HI);
    send_op(MODE_OR_MOD, 8'h18);
    send_op(MODE_SET_MOD, 8'hFF);
    send_op(MODE_SEND, 8'h00);
    send_op(MODE_SWAP, 8'hFF);
    send_op(MODE_ADD, 8'h04);
    send_op(MODE_ADD, 8'h00);
    send_op(MODE_ADD, 8'hFF);
    for (int c = 5; c <= 9; c++) send_op(MODE_ADD, BYTE_W'(c));
    send_op(MODE_SET_MOD, 8'h00);
    send_op(MODE_SPARE_6, 8'hAA);
    send_op(MODE_SPARE_7, 8'h55);
    send_op(MODE_SEND, 8'hFF);
    send_op(MODE_CLEAR, 8'h7E);
    send_op(MODE_SEND, 8'h81);
    wait_drained();
  endtask

  // bitmap report: empty read, bitmap edges, dropped codes
  task automatic test_bitmap_report();
    write_nkro(1'b1);
    send_op(MODE_SEND, 8'h3C);
    send_op(MODE_ADD, 8'h00);
    send_op(MODE_ADD, BYTE_W'(8 * KEY_SLOTS - 1));
    send_op(MODE_ADD, BYTE_W'(8 * KEY_SLOTS));
    send_op(MODE_ADD, 8'hDF);
    send_op(MODE_ADD, 8'hE3);
    send_op(MODE_SEND, 8'hC3);
    send_op(MODE_CLEAR, 8'h00);
    wait_drained();
  endtask

  // long receiver hold-off while operations keep coming
  task automatic test_input_stall();
    logic [MODE_W-1:0] op;
    logic [BYTE_W-1:0] val;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_cycles = 200;
    for (int n = 0; n < 16; n++) begin
      pick_random_op(op, val);
      send_op(op, val);
    end
    wait_drained();
  endtask

  // random traffic over idling phases and both report types
  task automatic test_random_traffic();
    logic [MODE_W-1:0] op;
    logic [BYTE_W-1:0] val;
    int tx_pct [4] = '{0, 55, 0, 24};
    int rx_pct [4] = '{0, 0, 55, 24};
    for (int ph = 0; ph < 4; ph++) begin
      write_nkro(ph[0]);
      tx_idle_pct = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      for (int n = 0; n < 20; n++) begin
        pick_random_op(op, val);
        send_op(op, val);
      end
      wait_drained();
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_slot_report();
    test_bitmap_report();
    test_input_stall();
    test_random_traffic();
    wait_drained();
    repeat (2 * OP_CYCLES_MAX) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS hid_keyboard_report_builder_top");
    end else begin
      $display("FAIL hid_keyboard_report_builder_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("FAIL hid_keyboard_report_builder_top");
    $finish;
  end

endmodule
